// ----- src/pdc_pkg.sv -----
// ----------------------------------------------------------------------------
// pdc_pkg - shared types and constants of the arm preset PD controller
// Operation and command codes, register indexes, reset values and limits.
// ----------------------------------------------------------------------------
package pdc_pkg;

	localparam int NUM_PRESETS = 3;
	localparam int DRIVE_LIMIT = 100;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 32;

	typedef enum logic [2:0] {
		OP_TICK    = 3'd0,
		OP_UP      = 3'd1,
		OP_DOWN    = 3'd2,
		OP_RELEASE = 3'd3,
		OP_MODE    = 3'd4
	} op_e;

	typedef enum logic [1:0] {
		CMD_NONE = 2'd0,
		CMD_SPIN = 2'd1,
		CMD_HOLD = 2'd2
	} cmd_e;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROP_GAIN   = 3'd0,
		REG_DERIV_GAIN  = 3'd1,
		REG_PRESET_LOW  = 3'd2,
		REG_PRESET_MID  = 3'd3,
		REG_PRESET_HIGH = 3'd4
	} reg_e;

	localparam logic [15:0] PROP_GAIN_RST   = 16'd128;
	localparam logic [15:0] DERIV_GAIN_RST  = 16'd0;
	localparam logic [15:0] PRESET_LOW_RST  = 16'd0;
	localparam logic [15:0] PRESET_MID_RST  = 16'd1368;
	localparam logic [15:0] PRESET_HIGH_RST = 16'd6720;

	localparam logic [1:0] PRESET_MAX = 2'(NUM_PRESETS - 1);
	localparam logic signed [7:0] DRIVE_POS = 8'(DRIVE_LIMIT);
	localparam logic signed [7:0] DRIVE_NEG = 8'(-DRIVE_LIMIT);
	localparam logic signed [23:0] DRIVE_LIM_HI = 24'(DRIVE_LIMIT);
	localparam logic signed [23:0] DRIVE_LIM_LO = 24'(-DRIVE_LIMIT);

	typedef logic [NUM_PRESETS-1:0][15:0] preset_arr_t;

	typedef struct packed {
		cmd_e               cmd;
		logic               law;
		logic signed [7:0]  pct;
		logic signed [15:0] target;
		logic [1:0]         idx;
		logic               auto_on;
	} step_t;

endpackage

// ----- src/pdc_step.sv -----
// ----------------------------------------------------------------------------
// pdc_step - mode, preset and error stage
// Decodes one word, updates mode, preset and error state, registers the
// error terms and the result fields for the control law stage.
// ----------------------------------------------------------------------------
module pdc_step (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       fire,
	input  logic [2:0]                 operation,
	input  logic signed [15:0]         measured_angle,
	input  pdc_pkg::preset_arr_t       presets,
	output pdc_pkg::step_t             step_s2,
	output logic signed [16:0]         err_s2,
	output logic signed [17:0]         diff_s2
);
	import pdc_pkg::*;

	logic               auto_q;
	logic [1:0]         sel_q;
	logic signed [15:0] target_q;
	logic signed [16:0] last_err_q;

	logic               nxt_auto;
	logic [1:0]         nxt_sel;
	logic signed [15:0] nxt_target;
	logic signed [16:0] err;
	logic signed [17:0] diff;
	step_t              step;

	always_comb begin
		nxt_auto   = auto_q;
		nxt_sel    = sel_q;
		nxt_target = target_q;
		step.cmd   = CMD_NONE;
		step.law   = 1'b0;
		step.pct   = '0;
		err  = {target_q[15], target_q} - {measured_angle[15], measured_angle};
		diff = {err[16], err} - {last_err_q[16], last_err_q};
		case (operation)
			OP_TICK: begin
				if (auto_q) begin
					step.cmd = CMD_SPIN;
					step.law = 1'b1;
				end
			end
			OP_UP: begin
				if (auto_q) begin
					if (sel_q < PRESET_MAX) begin
						nxt_sel    = sel_q + 2'd1;
						nxt_target = presets[nxt_sel];
					end
				end else begin
					step.cmd = CMD_SPIN;
					step.pct = DRIVE_POS;
				end
			end
			OP_DOWN: begin
				if (auto_q) begin
					if (sel_q != 2'd0) begin
						nxt_sel    = sel_q - 2'd1;
						nxt_target = presets[nxt_sel];
					end
				end else begin
					step.cmd = CMD_SPIN;
					step.pct = DRIVE_NEG;
				end
			end
			OP_RELEASE: begin
				if (!auto_q) step.cmd = CMD_HOLD;
			end
			OP_MODE: begin
				nxt_auto = ~auto_q;
				if (!auto_q) begin
					nxt_sel    = 2'd0;
					nxt_target = presets[0];
				end
			end
			default: ;
		endcase
		step.target  = nxt_target;
		step.idx     = nxt_sel;
		step.auto_on = nxt_auto;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_q     <= 1'b1;
			sel_q      <= 2'd0;
			target_q   <= '0;
			last_err_q <= '0;
		end else if (fire) begin
			auto_q   <= nxt_auto;
			sel_q    <= nxt_sel;
			target_q <= nxt_target;
			if (operation == OP_TICK) last_err_q <= err;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			step_s2 <= step;
			err_s2  <= err;
			diff_s2 <= diff;
		end
	end

endmodule

// ----- src/pdc_law.sv -----
// ----------------------------------------------------------------------------
// pdc_law - PD control law
// Registers the gain products, then sums, scales by 1/4096 with floor and
// saturates to the drive limit; manual and non-spin steps bypass the law.
// ----------------------------------------------------------------------------
module pdc_law (
	input  logic                clk,
	input  logic                load,
	input  logic [15:0]         prop_gain,
	input  logic [15:0]         deriv_gain,
	input  pdc_pkg::step_t      step_s2,
	input  logic signed [16:0]  err_s2,
	input  logic signed [17:0]  diff_s2,
	output pdc_pkg::step_t      step_s3,
	output logic signed [7:0]   drive_pct
);
	import pdc_pkg::*;

	logic signed [16:0] kp;
	logic signed [16:0] kd;
	logic signed [33:0] prod_p_s3;
	logic signed [34:0] prod_d_s3;
	logic signed [35:0] sum;
	logic signed [23:0] q;
	logic signed [7:0]  law_pct;

	assign kp = {1'b0, prop_gain};
	assign kd = {1'b0, deriv_gain};

	always_ff @(posedge clk) begin
		if (load) begin
			prod_p_s3 <= 34'(kp) * 34'(err_s2);
			prod_d_s3 <= 35'(kd) * 35'(diff_s2);
			step_s3   <= step_s2;
		end
	end

	always_comb begin
		sum = {{2{prod_p_s3[33]}}, prod_p_s3} + {prod_d_s3[34], prod_d_s3};
		q   = sum[35:12];
		if (q > DRIVE_LIM_HI)
			law_pct = DRIVE_POS;
		else if (q < DRIVE_LIM_LO)
			law_pct = DRIVE_NEG;
		else
			law_pct = q[7:0];
		if (step_s3.cmd != CMD_SPIN)
			drive_pct = '0;
		else if (step_s3.law)
			drive_pct = law_pct;
		else
			drive_pct = step_s3.pct;
	end

endmodule

// ----- src/preset_arm_pd_controller.sv -----
// ----------------------------------------------------------------------------
// preset_arm_pd_controller - arm position controller with preset targets
//
//   channel   dir  handshake               word
//   s_axis    in   s_tvalid / s_tready     operation, measured_angle
//   m_axis    out  m_tvalid / m_tready     command, percent, target, index, mode
//   cfg       in   cfg_valid / cfg_ready   register index, 16-bit value
//
// One word per cycle while m_tready does not stall the output; the result passes
// the input register, mode/error stage, product register and result register.
// Reset returns mode, preset, target, error history and gains to defaults.
// Each stage advances whenever the one after it is empty or moving, so a
// stall on the output fills the empty stages before the input backs up.
// ----------------------------------------------------------------------------
module preset_arm_pd_controller (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// [2:0] operation, [18:3] measured_angle
	input  logic [pdc_pkg::S_TDATA_W-1:0]         s_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// [1:0] drive_command, [9:2] drive_percent, [25:10] target_angle,
	// [27:26] preset_index, [28] auto_mode
	output logic [pdc_pkg::M_TDATA_W-1:0]         m_tdata,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [pdc_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [pdc_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import pdc_pkg::*;

	logic [15:0]        prop_gain_q;
	logic [15:0]        deriv_gain_q;
	preset_arr_t        presets_q;

	logic               v1_q, v2_q, v3_q, ov_q;
	logic               rdy1, rdy2, rdy3, rdy_out;
	logic [2:0]         op_s1;
	logic signed [15:0] angle_s1;

	step_t              step_s2;
	step_t              step_s3;
	logic signed [16:0] err_s2;
	logic signed [17:0] diff_s2;
	logic signed [7:0]  drive_pct;
	logic [M_TDATA_W-1:0] out_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q  <= PROP_GAIN_RST;
			deriv_gain_q <= DERIV_GAIN_RST;
			presets_q[0] <= PRESET_LOW_RST;
			presets_q[1] <= PRESET_MID_RST;
			presets_q[2] <= PRESET_HIGH_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PROP_GAIN:   prop_gain_q  <= cfg_data;
				REG_DERIV_GAIN:  deriv_gain_q <= cfg_data;
				REG_PRESET_LOW:  presets_q[0] <= cfg_data;
				REG_PRESET_MID:  presets_q[1] <= cfg_data;
				REG_PRESET_HIGH: presets_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign rdy_out  = !ov_q || m_tready;
	assign rdy3     = !v3_q || rdy_out;
	assign rdy2     = !v2_q || rdy3;
	assign rdy1     = !v1_q || rdy2;
	assign s_tready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (rdy1)    v1_q <= s_tvalid;
			if (rdy2)    v2_q <= v1_q;
			if (rdy3)    v3_q <= v2_q;
			if (rdy_out) ov_q <= v3_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && s_tvalid) begin
			op_s1    <= s_tdata[2:0];
			angle_s1 <= s_tdata[18:3];
		end
	end

	pdc_step u_step (
		.clk            (clk),
		.arst_n         (arst_n),
		.fire           (v1_q && rdy2),
		.operation      (op_s1),
		.measured_angle (angle_s1),
		.presets        (presets_q),
		.step_s2        (step_s2),
		.err_s2         (err_s2),
		.diff_s2        (diff_s2)
	);

	pdc_law u_law (
		.clk        (clk),
		.load       (v2_q && rdy3),
		.prop_gain  (prop_gain_q),
		.deriv_gain (deriv_gain_q),
		.step_s2    (step_s2),
		.err_s2     (err_s2),
		.diff_s2    (diff_s2),
		.step_s3    (step_s3),
		.drive_pct  (drive_pct)
	);

	always_ff @(posedge clk) begin
		if (rdy_out && v3_q) begin
			out_q <= {3'b000, step_s3.auto_on, step_s3.idx, step_s3.target,
				drive_pct, step_s3.cmd};
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = out_q;

endmodule
